// File: hdl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
// no dependencies; compiled first

package hcbp_pkg;

   // field widths of the request and response channels
   localparam int FUNC_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int WORD_W = 32;
   localparam int LEN_W = 6;
   localparam int BYTE_W = 8;
   localparam int PAD_W = 3;
   localparam int ACC_W = 7;
   localparam int CNT_W = 3;
   localparam int NEED_W = 4;

   // one code table entry holds the code word and its length
   localparam int ENTRY_W = WORD_W + LEN_W;

   // defaults for the top level parameters
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int NUM_SYMBOLS_DEF = 256;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   // one response item
   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic byte_valid;
      logic [PAD_W-1:0] pad_count;
      logic last;
   } rsp_type;

endpackage

// File: hdl/hcbp_if.sv
// valid/ready channel interfaces for request and response transfers
// depends on hcbp_pkg

interface hcbp_req_if;
   logic valid;
   logic ready;
   logic [hcbp_pkg::FUNC_W-1:0] func;
   logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
   logic [hcbp_pkg::WORD_W-1:0] code_word;
   logic [hcbp_pkg::LEN_W-1:0] code_length;

   modport source (output valid, func, symbol, code_word, code_length, input ready);
   modport sink (input valid, func, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic valid;
   logic ready;
   logic [hcbp_pkg::BYTE_W-1:0] packed_byte;
   logic byte_valid;
   logic [hcbp_pkg::PAD_W-1:0] pad_count;
   logic last;

   modport source (output valid, packed_byte, byte_valid, pad_count, last, input ready);
   modport sink (input valid, packed_byte, byte_valid, pad_count, last, output ready);
endinterface

// File: hdl/huffman_code_bit_packer_top.sv
// huffman encoder back end: code table ram plus msb-first bit packer
// depends on hcbp_pkg, hcbp_if (hcbp_req_if, hcbp_rsp_if) and hcbp_ram
//
// usage
//   req_ch carries one command per transfer: load a code table entry,
//   encode one symbol, or flush the partial byte. rsp_ch returns the
//   completed bytes, each as one transfer; last marks the final one
//   of a command. a load returns nothing, a flush returns exactly one
//   transfer (byte_valid 0 when no bits were pending).
// sequence
//   load: taken back to back.
//   encode: the entry is fetched through the registered ram read and
//   the read state, then the shared shift/merge unit produces the
//   output bytes and finally merges leftover bits when any are left
//   or no byte completes.
//   flush: returns its one transfer once the output slot is free.
//   the shift/merge unit sets the rate, one byte per cycle unless rsp_ch stalls;
//   req_ch.ready is high only while the sequencer is idle.
// reset
//   synchronous, active high; clears the sequencer state, the
//   accumulator, the pending bit count and the output valid flag. the
//   code table is not cleared: load an entry before encoding its symbol.
// back pressure
//   a single output register holds a result; while rsp_ch stalls the
//   sequencer waits with any next byte; only an idle one takes requests.

module huffman_code_bit_packer_top #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
   parameter int NUM_SYMBOLS = hcbp_pkg::NUM_SYMBOLS_DEF
) (
   input logic clock,
   input logic reset,
   hcbp_req_if.sink req_ch,
   hcbp_rsp_if.source rsp_ch
);

   localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int W = hcbp_pkg::WORD_W;
   localparam int LW = hcbp_pkg::LEN_W;

   // sequencer and packer state
   hcbp_pkg::state_type state_ff, state_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [hcbp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [hcbp_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   hcbp_pkg::rsp_type rsp_ff, rsp_in;

   // code table port signals
   logic ram_wr_en, ram_rd_en;
   logic [hcbp_pkg::ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic [W-1:0] rd_word;
   logic [LW-1:0] rd_len, len_cap;

   // shared shift/merge unit
   logic req_fire, sym_in_range, slot_free, enough, emit;
   logic [hcbp_pkg::NEED_W-1:0] need;
   logic [LW-1:0] rem_left;
   logic [4:0] shamt;
   logic [W-1:0] shifted;
   logic [hcbp_pkg::BYTE_W-1:0] need_mask, shift_byte, flush_byte;
   logic [hcbp_pkg::ACC_W-1:0] rem_mask, merged;
   logic [2:0] rem_small;
   logic [hcbp_pkg::PAD_W-1:0] pad;

   assign req_ch.ready = (state_ff == hcbp_pkg::ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign sym_in_range = {1'b0, req_ch.symbol} < 9'(NUM_SYMBOLS);

   // saturate the code length once, at load time
   assign len_cap = (req_ch.code_length > LW'(LEN_CAP)) ? LW'(LEN_CAP)
                                                        : req_ch.code_length;
   assign ram_wr_data = {req_ch.code_word, len_cap};
   assign ram_wr_en = req_fire && (req_ch.func == hcbp_pkg::FUNC_LOAD) && sym_in_range;
   assign ram_rd_en = req_fire && (req_ch.func == hcbp_pkg::FUNC_ENCODE) && sym_in_range;
   assign rd_word = ram_rd_data[hcbp_pkg::ENTRY_W-1:LW];
   assign rd_len = ram_rd_data[LW-1:0];

   hcbp_ram #(
      .WIDTH(hcbp_pkg::ENTRY_W),
      .DEPTH(NUM_SYMBOLS)
   ) u_code_table (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(req_ch.symbol[AW-1:0]),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(req_ch.symbol[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // output slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // bits still needed to complete the pending byte, 1 to 8
   assign need = hcbp_pkg::NEED_W'(4'd8 - {1'b0, cnt_ff});
   assign enough = rem_ff >= {2'b00, need};
   assign rem_left = rem_ff - {2'b00, need};
   assign shamt = rem_left[4:0];
   assign shifted = rd_word >> shamt;
   assign need_mask = 8'((9'd1 << need) - 9'd1);
   assign shift_byte = 8'({1'b0, acc_ff} << need) | (shifted[7:0] & need_mask);

   // fewer code bits left than needed: fold them into the accumulator
   assign rem_small = rem_ff[2:0];
   assign rem_mask = 7'((8'd1 << rem_small) - 8'd1);
   assign merged = 7'(acc_ff << rem_small) | (rd_word[6:0] & rem_mask);

   assign pad = 3'(4'd8 - {1'b0, cnt_ff});
   assign flush_byte = 8'({1'b0, acc_ff} << pad);

   assign emit = (state_ff == hcbp_pkg::ST_SHIFT) && enough && slot_free;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in = rsp_ff;
      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.func == hcbp_pkg::FUNC_ENCODE && sym_in_range) begin
                  state_in = hcbp_pkg::ST_READ;
               end else if (req_ch.func == hcbp_pkg::FUNC_FLUSH) begin
                  state_in = hcbp_pkg::ST_FLUSH;
               end
            end
         end
         hcbp_pkg::ST_READ: begin
            rem_in = rd_len;
            state_in = hcbp_pkg::ST_SHIFT;
         end
         hcbp_pkg::ST_SHIFT: begin
            if (enough) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.packed_byte = shift_byte;
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.pad_count = '0;
                  rsp_in.last = rem_left < LW'(8);
                  rem_in = rem_left;
                  acc_in = '0;
                  cnt_in = '0;
                  if (rem_left == '0) begin
                     state_in = hcbp_pkg::ST_IDLE;
                  end
               end
            end else begin
               acc_in = merged;
               cnt_in = cnt_ff + rem_small;
               rem_in = '0;
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         hcbp_pkg::ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.last = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_in.packed_byte = '0;
                  rsp_in.byte_valid = 1'b0;
                  rsp_in.pad_count = '0;
               end else begin
                  rsp_in.packed_byte = flush_byte;
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.pad_count = pad;
               end
               acc_in = '0;
               cnt_in = '0;
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcbp_pkg::ST_IDLE;
         rem_ff <= '0;
         acc_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.packed_byte = rsp_ff.packed_byte;
   assign rsp_ch.byte_valid = rsp_ff.byte_valid;
   assign rsp_ch.pad_count = rsp_ff.pad_count;
   assign rsp_ch.last = rsp_ff.last;

   // accumulator holds no bits above the pending count
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> cnt_ff) == '0)
      else $error("accumulator has bits above pending count");

   // remaining code length never exceeds a 32-bit code
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= LW'(32))
      else $error("remaining code length out of range");

   // an emitted byte shows up on the response channel next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_ch.valid && rsp_ch.byte_valid)
      else $error("emitted byte not presented");

   // no new request is taken while a byte is still being produced
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hcbp_pkg::ST_SHIFT || state_ff == hcbp_pkg::ST_READ) |-> !req_ch.ready)
      else $error("request accepted while encoding");

endmodule

// File: hdl/hcbp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
